// File: src/hms_pkg.sv
`timescale 1ns / 1ps
// hms_pkg: shared constants and types for the heightmap height sampler
// widths, register indexes, opcodes and sequencer states; no dependencies

package hms_pkg;

	localparam int unsigned MAX_SIDE  = 256;
	localparam int unsigned SIDE_W    = 9;
	localparam int unsigned GAIN_W    = 17;
	localparam int unsigned COORD_W   = 18;
	localparam int unsigned ADDR_W    = 16;
	localparam int unsigned SAMPLE_W  = 8;
	localparam int unsigned HEIGHT_W  = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = GAIN_W;

	localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_DEPTH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_GAIN = 2'd2;

	localparam logic [SIDE_W-1:0] SIDE_RST = 9'd256;
	localparam logic [GAIN_W-1:0] GAIN_RST = 17'd6554;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_GEOM,
		S_ADDR,
		S_RD_TL,
		S_RD_TR,
		S_RD_BL,
		S_RD_BR,
		S_INTERP,
		S_SCALE
	} state_t;

endpackage

// File: src/heightmap_height_sampler.sv
`timescale 1ns / 1ps
// heightmap_height_sampler: sample store plus triangle interpolation of queries
// depends on hms_pkg
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per transfer. An item
//   with opcode write stores sample_value at sample_index and gives no result;
//   an item with opcode query gives one result on the
//   output channel (out_valid/out_ready): height in Q8.8 and in_range.
//   A query inside the grid passes through the cell search, the corner address,
//   four reads of the single read port of the sample memory, interpolation and
//   the gain multiply before out_valid; a query outside the grid goes from the
//   cell search straight to the gain multiply. The next item is taken in the
//   cycle after the result is loaded.
//   The result sits in an output register; a stalled receiver only holds the
//   block once a second result is ready to be loaded.
//   Configuration writes (cfg_valid/cfg_ready, always ready) set map_width,
//   map_depth and height_gain; they are meant for idle periods only.
//   Reset restores the register defaults and empties the output register; the
//   sample memory is not cleared and must be written before it is queried.

module heightmap_height_sampler
	import hms_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DAT_W-1:0]        cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        opcode,
	input  logic [ADDR_W-1:0]           sample_index,
	input  logic [SAMPLE_W-1:0]         sample_value,
	input  logic signed [COORD_W-1:0]   query_x,
	input  logic signed [COORD_W-1:0]   query_z,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [HEIGHT_W-1:0]         height,
	output logic                        in_range
);

	state_t state_q, state_d;

	logic [SIDE_W-1:0] width_q, depth_q;
	logic [GAIN_W-1:0] gain_q;

	logic [SAMPLE_W-1:0] height_store_q [2**ADDR_W];
	logic [SAMPLE_W-1:0] rd_data_q;
	logic [ADDR_W-1:0]   rd_addr;
	logic                rd_en;
	logic                wr_en;

	logic signed [COORD_W-1:0] x_q, z_q;
	logic [7:0] col_q, row_q, s_q, t_q;
	logic       range_q;
	logic [ADDR_W-1:0] base_q;
	logic [SAMPLE_W-1:0] tl_q, tr_q, bl_q;
	logic [HEIGHT_W-1:0] v_q;

	logic                out_valid_q;
	logic [HEIGHT_W-1:0] height_q;
	logic                in_range_q;
	logic                ld_out;

	// effective grid size
	logic [SIDE_W-1:0] w_eff, d_eff, w_m1, d_m1, w_m2, d_m2;
	logic signed [COORD_W:0] cq, dq;
	logic outside;

	// interpolation
	logic               upper;
	logic [8:0]         st_sum;
	logic [SAMPLE_W-1:0] a_sel, br;
	logic [8:0]         f1, f2;
	logic signed [8:0]  d1, d2;
	logic signed [18:0] p1, p2;
	logic signed [20:0] v_full;

	// gain
	logic [33:0] prod_full;
	logic [17:0] scaled;
	logic [HEIGHT_W-1:0] height_next;

	logic [16:0] base_full;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign height    = height_q;
	assign in_range  = in_range_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= SIDE_RST;
			depth_q <= SIDE_RST;
			gain_q  <= GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MAP_WIDTH:   width_q <= cfg_data[SIDE_W-1:0];
				REG_MAP_DEPTH:   depth_q <= cfg_data[SIDE_W-1:0];
				REG_HEIGHT_GAIN: gain_q  <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// grid geometry
	always_comb begin
		w_eff = (width_q > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : width_q;
		d_eff = (depth_q > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : depth_q;
		w_m1  = w_eff - 9'd1;
		d_m1  = d_eff - 9'd1;
		w_m2  = w_eff - 9'd2;
		d_m2  = d_eff - 9'd2;
		cq = $signed({x_q[COORD_W-1], x_q}) + $signed({3'b000, w_m1, 7'b0000000});
		dq = $signed({3'b000, d_m1, 7'b0000000}) - $signed({z_q[COORD_W-1], z_q});
		outside = (w_eff < 9'd2) || (d_eff < 9'd2) || cq[COORD_W] || dq[COORD_W]
			|| (cq[COORD_W-1:8] > {1'b0, w_m2}) || (dq[COORD_W-1:8] > {1'b0, d_m2});
	end

	assign base_full = 17'(row_q) * 17'(w_eff) + 17'(col_q);

	// read address sequence over the four corners
	always_comb begin
		case (state_q)
			S_RD_TR: rd_addr = base_q + ADDR_W'(1);
			S_RD_BL: rd_addr = base_q + ADDR_W'(w_eff);
			S_RD_BR: rd_addr = base_q + ADDR_W'(w_eff) + ADDR_W'(1);
			default: rd_addr = base_q;
		endcase
	end

	// triangle interpolation, bottom-right sample comes straight from the memory
	always_comb begin
		br     = rd_data_q;
		st_sum = {1'b0, s_q} + {1'b0, t_q};
		upper  = (st_sum <= 9'd256);
		if (upper) begin
			a_sel = tl_q;
			f1    = {1'b0, s_q};
			f2    = {1'b0, t_q};
			d1    = $signed({1'b0, tr_q}) - $signed({1'b0, tl_q});
			d2    = $signed({1'b0, bl_q}) - $signed({1'b0, tl_q});
		end else begin
			a_sel = br;
			f1    = 9'd256 - {1'b0, s_q};
			f2    = 9'd256 - {1'b0, t_q};
			d1    = $signed({1'b0, bl_q}) - $signed({1'b0, br});
			d2    = $signed({1'b0, tr_q}) - $signed({1'b0, br});
		end
		p1     = 19'($signed({1'b0, f1})) * 19'(d1);
		p2     = 19'($signed({1'b0, f2})) * 19'(d2);
		v_full = $signed({5'b00000, a_sel, 8'b00000000}) + 21'(p1) + 21'(p2);
	end

	// gain with round half up and saturation
	always_comb begin
		prod_full   = 34'(v_q) * 34'(gain_q) + 34'd32768;
		scaled      = prod_full[33:16];
		height_next = (|scaled[17:16]) ? {HEIGHT_W{1'b1}} : scaled[15:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_en    = 1'b0;
		ld_out   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && opcode == OP_QUERY) begin
					state_d = S_GEOM;
				end
			end
			S_GEOM: begin
				state_d = outside ? S_SCALE : S_ADDR;
			end
			S_ADDR: begin
				state_d = S_RD_TL;
			end
			S_RD_TL: begin
				rd_en   = 1'b1;
				state_d = S_RD_TR;
			end
			S_RD_TR: begin
				rd_en   = 1'b1;
				state_d = S_RD_BL;
			end
			S_RD_BL: begin
				rd_en   = 1'b1;
				state_d = S_RD_BR;
			end
			S_RD_BR: begin
				rd_en   = 1'b1;
				state_d = S_INTERP;
			end
			S_INTERP: begin
				state_d = S_SCALE;
			end
			S_SCALE: begin
				if (!out_valid_q || out_ready) begin
					ld_out  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign wr_en = in_valid && in_ready && (opcode == OP_WRITE);

	// sample memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			height_store_q[sample_index] <= sample_value;
		end
		if (rd_en) begin
			rd_data_q <= height_store_q[rd_addr];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_q <= query_x;
			z_q <= query_z;
		end
		if (state_q == S_GEOM) begin
			col_q   <= cq[15:8];
			row_q   <= dq[15:8];
			s_q     <= cq[7:0];
			t_q     <= dq[7:0];
			range_q <= !outside;
			v_q     <= '0;
		end
		if (state_q == S_ADDR) begin
			base_q <= base_full[ADDR_W-1:0];
		end
		if (state_q == S_RD_TR) begin
			tl_q <= rd_data_q;
		end
		if (state_q == S_RD_BL) begin
			tr_q <= rd_data_q;
		end
		if (state_q == S_RD_BR) begin
			bl_q <= rd_data_q;
		end
		if (state_q == S_INTERP) begin
			v_q <= v_full[20] ? '0 : v_full[15:0];
		end
		if (ld_out) begin
			height_q   <= height_next;
			in_range_q <= range_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
